/* rtl/jpfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpfs_pkg
// Types, constants and the build-time gain table for the joint particle
// field block.
// ----------------------------------------------------------------------------
package jpfs_pkg;

    // Stream widths, whole bytes
    localparam int IN_W  = 136;
    localparam int OUT_W = 144;

    // Look entry: {red flag, alpha, point size}
    localparam int LOOK_W    = 23;
    localparam int SIZE_W    = 14;
    localparam int SIZE_MAX  = 10000;
    localparam logic [LOOK_W-1:0] LOOK_RESET = {1'b0, 8'd40, 14'd0};

    // Gain table geometry and force range
    localparam int GAIN_DEPTH = 1024;
    localparam int GAIN_IDX_W = 10;
    localparam int RANGE_SQ   = 900;
    localparam logic signed [32:0] RANGE_Q16 = 33'sd1966080;

    // Fixed-point coefficients, Q16 with a clear sign bit
    localparam logic signed [16:0] DAMP_Q16 = 17'sd64881;
    localparam logic signed [16:0] STEP_Q16 = 17'sd58982;

    localparam logic [63:0] K_REPEL   = 64'd214748365;
    localparam logic [63:0] K_ATTRACT = 64'd858993459;

    typedef enum logic [1:0] {
        ACT_FRAME = 2'd0,
        ACT_JOINT = 2'd1,
        ACT_INTEG = 2'd2,
        ACT_READ  = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FCLEAR,
        ST_SWEEP,
        ST_DRAIN,
        ST_EMIT,
        ST_READ,
        ST_RESP
    } state_t;

    typedef logic signed [31:0] gain_rom_t [GAIN_DEPTH];

    // Saturate a widened sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Shift-subtract long division, build time only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bitv;
        n    = n_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic pow20_fits(input logic [63:0] y, input logic [63:0] target);
        logic [63:0] p2;
        logic [63:0] p4;
        logic [63:0] p5;
        logic [63:0] p10;
        logic fits;
        p2  = (y * y) >> 24;
        p4  = (p2 * p2) >> 24;
        p5  = (p4 * y) >> 24;
        p10 = (p5 * p5) >> 24;
        if (p10 >= 64'h1_0000_0000)
            fits = 1'b0;
        else
            fits = ((p10 * p10) >> 24) <= target;
        return fits;
    endfunction

    // One entry: 2*(0.4/r^3 - 1.6/r^2.1) in Q4.28, r^2 = k
    function automatic logic signed [31:0] gain_entry(input logic [63:0] k);
        logic [63:0] s;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] t1;
        logic [63:0] t2;
        s  = isqrt64(k << 32);
        lo = 64'd1 << 24;
        hi = 64'd3 << 23;
        for (int i = 0; i < 24; i++) begin
            if (hi - lo > 64'd1) begin
                mid = (lo + hi) >> 1;
                if (pow20_fits(mid, k << 24))
                    lo = mid;
                else
                    hi = mid;
            end
        end
        t1 = udiv64(K_REPEL << 16, k * s);
        t2 = udiv64(K_ATTRACT << 24, k * lo);
        return sat32($signed({2'b00, t1[31:0]}) - $signed({2'b00, t2[31:0]}));
    endfunction

    function automatic gain_rom_t build_gain();
        gain_rom_t t;
        for (int k = 0; k < GAIN_DEPTH; k++) begin
            if (k >= 1 && k < RANGE_SQ)
                t[k] = gain_entry(64'(k));
            else
                t[k] = '0;
        end
        t[0] = t[1];
        return t;
    endfunction

endpackage

/* rtl/jpfs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpfs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module jpfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/joint_particle_field_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_particle_field_step_top
// Particle store moved by joint positions: force sweep, emission ring,
// integration and single-particle readout.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel; tuser carries the action (frame start,
//   joint, integrate, read). Only a read gives a result, on m_axis.
//   Particle state sits in four RAMs with one read and one write port each;
//   every sweep reads one particle per cycle through a six-stage
//   read-modify-write pipeline and writes it back at the end.
//   Work per item:
//     frame start  force clearing pass
//     joint        force sweep, pipeline drain, then EMIT_PER_JOINT emissions
//     integrate    integration sweep and pipeline drain
//     read         store read, then the output register
//   The single read port of the stores sets the one-particle-per-cycle pace.
//   After reset a clearing pass writes the reset values into every store;
//   s_axis_tready stays low during it.
//   A stalled receiver holds the result in the output register; further
//   items are still taken, and a new read waits until the register frees.
// ----------------------------------------------------------------------------
module joint_particle_field_step_top #(
    parameter int PARTICLE_COUNT = 16384,
    parameter int EMIT_PER_JOINT = 10
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: beat_mark[0], frame_alpha[8:1], frame_point_size[22:9],
    //        joint_x[54:23], joint_y[86:55], joint_z[118:87], read_index[132:119]
    input  logic [jpfs_pkg::IN_W-1:0]  s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], red[103:96],
    //        green[111:104], blue[119:112], alpha[127:120], size_out[141:128]
    output logic [jpfs_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(PARTICLE_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PARTICLE_COUNT - 1);
    localparam int EC_W = $clog2(EMIT_PER_JOINT + 1);
    localparam logic [EC_W-1:0] EMIT_LAST = EC_W'(EMIT_PER_JOINT - 1);
    localparam jpfs_pkg::gain_rom_t GAIN_ROM = jpfs_pkg::build_gain();

    // Input fields
    logic                       beat_mark;
    logic [7:0]                 frame_alpha;
    logic [13:0]                frame_point_size;
    logic signed [31:0]         joint_x;
    logic signed [31:0]         joint_y;
    logic signed [31:0]         joint_z;
    logic [13:0]                read_index;
    jpfs_pkg::act_t             action;

    assign action           = jpfs_pkg::act_t'(s_axis_tuser);
    assign beat_mark        = s_axis_tdata[0];
    assign frame_alpha      = s_axis_tdata[8:1];
    assign frame_point_size = s_axis_tdata[22:9];
    assign joint_x          = s_axis_tdata[54:23];
    assign joint_y          = s_axis_tdata[86:55];
    assign joint_z          = s_axis_tdata[118:87];
    assign read_index       = s_axis_tdata[132:119];

    // Control state
    jpfs_pkg::state_t           state_reg, state_next;
    logic [IDX_W-1:0]           cnt_reg, cnt_next;
    logic [IDX_W-1:0]           emit_slot_reg, emit_slot_next;
    logic [EC_W-1:0]            emit_cnt_reg, emit_cnt_next;
    logic [1:0]                 beat_reg, beat_next;
    logic [jpfs_pkg::LOOK_W-1:0] frame_look_reg, frame_look_next;
    logic                       mode_joint_reg, mode_joint_next;
    logic                       m_vld_reg, m_vld_next;
    logic                       in_acc;
    logic                       out_load;
    logic                       pipe_busy;

    // Latched item payload
    logic signed [31:0]         jnt_reg [3];
    logic [IDX_W-1:0]           rd_addr_reg;
    logic                       rd_oor_reg;
    logic [jpfs_pkg::OUT_W-1:0] out_reg;

    // Memory ports
    logic                       pos_we, vel_we, frc_we, look_we;
    logic [IDX_W-1:0]           pos_waddr, vel_waddr, frc_waddr, look_waddr, raddr;
    logic [95:0]                pos_wdata, vel_wdata, frc_wdata;
    logic [jpfs_pkg::LOOK_W-1:0] look_wdata;
    logic [95:0]                pos_rd, vel_rd, frc_rd;
    logic [jpfs_pkg::LOOK_W-1:0] look_rd;

    // Pipeline registers
    logic                       s0_vld_reg, s1_vld_reg, s2_vld_reg;
    logic                       s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic [IDX_W-1:0]           s0_idx_reg, s1_idx_reg, s2_idx_reg;
    logic [IDX_W-1:0]           s3_idx_reg, s4_idx_reg, s5_idx_reg;
    logic                       s1_near_reg, s2_near_reg, s3_hit_reg, s4_hit_reg, s5_hit_reg;
    logic signed [21:0]         s1_d_reg [3];
    logic signed [21:0]         s2_d_reg [3];
    logic signed [21:0]         s3_d_reg [3];
    logic signed [21:0]         s4_d_reg [3];
    logic signed [31:0]         s1_pos_reg [3];
    logic signed [31:0]         s2_pos_reg [3];
    logic signed [31:0]         s3_pos_reg [3];
    logic signed [31:0]         s1_frc_reg [3];
    logic signed [31:0]         s2_frc_reg [3];
    logic signed [31:0]         s3_frc_reg [3];
    logic signed [31:0]         s4_frc_reg [3];
    logic signed [31:0]         s5_frc_reg [3];
    logic signed [48:0]         s1_pv_reg [3];
    logic signed [48:0]         s1_pf_reg [3];
    logic [41:0]                s2_sq_reg [3];
    logic signed [31:0]         s2_v_reg [3];
    logic signed [31:0]         s3_v_reg [3];
    logic signed [31:0]         s4_v_reg [3];
    logic signed [31:0]         s5_v_reg [3];
    logic signed [48:0]         s3_pp_reg [3];
    logic [jpfs_pkg::GAIN_IDX_W-1:0] s3_k_reg;
    logic signed [31:0]         s4_g_reg;
    logic signed [31:0]         s4_p_reg [3];
    logic signed [31:0]         s5_p_reg [3];
    logic signed [53:0]         s5_prod_reg [3];

    // Stage combinational values
    logic signed [32:0]         d_full [3];
    logic                       near_all;
    logic [43:0]                sq_sum;
    logic signed [31:0]         frc_new [3];

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == jpfs_pkg::ST_IDLE);
    assign pipe_busy     = s0_vld_reg || s1_vld_reg || s2_vld_reg
                        || s3_vld_reg || s4_vld_reg || s5_vld_reg;
    assign out_load      = (state_reg == jpfs_pkg::ST_RESP) && (!m_vld_reg || m_axis_tready);

    // ------------------------------------------------------------------
    // Sequencer: next state, counters and frame look
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        emit_slot_next  = emit_slot_reg;
        emit_cnt_next   = emit_cnt_reg;
        beat_next       = beat_reg;
        frame_look_next = frame_look_reg;
        mode_joint_next = mode_joint_reg;
        m_vld_next      = m_vld_reg;

        if (out_load)
            m_vld_next = 1'b1;
        else if (m_axis_tready)
            m_vld_next = 1'b0;

        case (state_reg)
            jpfs_pkg::ST_CLEAR, jpfs_pkg::ST_FCLEAR, jpfs_pkg::ST_SWEEP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_LAST)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == jpfs_pkg::ST_SWEEP) ? jpfs_pkg::ST_DRAIN
                                                                    : jpfs_pkg::ST_IDLE;
                end
            end
            jpfs_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (action)
                        jpfs_pkg::ACT_FRAME:
                        begin
                            // Advance the beat; every third beat turns red
                            logic red;
                            red = 1'b0;
                            if (beat_mark)
                            begin
                                if (beat_reg == 2'd2)
                                begin
                                    beat_next = 2'd0;
                                    red       = 1'b1;
                                end
                                else
                                begin
                                    beat_next = beat_reg + 2'd1;
                                end
                            end
                            frame_look_next = {red, frame_alpha,
                                               (frame_point_size > 14'(jpfs_pkg::SIZE_MAX))
                                               ? 14'(jpfs_pkg::SIZE_MAX) : frame_point_size};
                            state_next = jpfs_pkg::ST_FCLEAR;
                        end
                        jpfs_pkg::ACT_JOINT:
                        begin
                            mode_joint_next = 1'b1;
                            state_next      = jpfs_pkg::ST_SWEEP;
                        end
                        jpfs_pkg::ACT_INTEG:
                        begin
                            mode_joint_next = 1'b0;
                            state_next      = jpfs_pkg::ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = jpfs_pkg::ST_READ;
                        end
                    endcase
                end
            end
            jpfs_pkg::ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    emit_cnt_next = '0;
                    state_next    = mode_joint_reg ? jpfs_pkg::ST_EMIT : jpfs_pkg::ST_IDLE;
                end
            end
            jpfs_pkg::ST_EMIT:
            begin
                emit_slot_next = (emit_slot_reg == IDX_LAST) ? '0 : emit_slot_reg + 1'b1;
                emit_cnt_next  = emit_cnt_reg + 1'b1;
                if (emit_cnt_reg == EMIT_LAST)
                    state_next = jpfs_pkg::ST_IDLE;
            end
            jpfs_pkg::ST_READ:
            begin
                state_next = jpfs_pkg::ST_RESP;
            end
            jpfs_pkg::ST_RESP:
            begin
                if (out_load)
                    state_next = jpfs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = jpfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= jpfs_pkg::ST_CLEAR;
            cnt_reg        <= '0;
            emit_slot_reg  <= '0;
            emit_cnt_reg   <= '0;
            beat_reg       <= '0;
            frame_look_reg <= {1'b0, 8'd0, 14'd0};
            mode_joint_reg <= 1'b0;
            m_vld_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            emit_slot_reg  <= emit_slot_next;
            emit_cnt_reg   <= emit_cnt_next;
            beat_reg       <= beat_next;
            frame_look_reg <= frame_look_next;
            mode_joint_reg <= mode_joint_next;
            m_vld_reg      <= m_vld_next;
        end
    end

    // Latch joint and read address on accept
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            jnt_reg[0]  <= joint_x;
            jnt_reg[1]  <= joint_y;
            jnt_reg[2]  <= joint_z;
            rd_addr_reg <= IDX_W'(read_index);
            rd_oor_reg  <= {3'b000, read_index} >= 17'(PARTICLE_COUNT);
        end
    end

    // ------------------------------------------------------------------
    // Sweep pipeline valid and index chain
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= (state_reg == jpfs_pkg::ST_SWEEP);
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    // Stage 1 offsets from the joint and range test, stage 3 squared-distance sum, stage 5 force update
    always_comb
    begin
        near_all = 1'b1;
        for (int c = 0; c < 3; c++)
        begin
            d_full[c] = {pos_rd[32*c+31], pos_rd[32*c +: 32]} - {jnt_reg[c][31], jnt_reg[c]};
            if (d_full[c] >= jpfs_pkg::RANGE_Q16 || d_full[c] <= -jpfs_pkg::RANGE_Q16)
                near_all = 1'b0;
        end
        sq_sum = {2'b00, s2_sq_reg[0]} + {2'b00, s2_sq_reg[1]} + {2'b00, s2_sq_reg[2]};
        for (int c = 0; c < 3; c++)
        begin
            frc_new[c] = jpfs_pkg::sat32({{8{s5_prod_reg[c][53]}}, s5_prod_reg[c][53:28]}
                                         + {{2{s5_frc_reg[c][31]}}, s5_frc_reg[c]});
        end
    end

    // Stages 1 to 5: distance, gain and integration arithmetic
    always_ff @(posedge clk)
    begin
        s0_idx_reg  <= cnt_reg;
        s1_idx_reg  <= s0_idx_reg;
        s2_idx_reg  <= s1_idx_reg;
        s3_idx_reg  <= s2_idx_reg;
        s4_idx_reg  <= s3_idx_reg;
        s5_idx_reg  <= s4_idx_reg;

        s1_near_reg <= near_all;
        s2_near_reg <= s1_near_reg;
        s3_hit_reg  <= s2_near_reg && (sq_sum != '0)
                    && (sq_sum[43:32] < 12'(jpfs_pkg::RANGE_SQ));
        s3_k_reg    <= sq_sum[41:32];
        s4_hit_reg  <= s3_hit_reg;
        s5_hit_reg  <= s4_hit_reg;
        s4_g_reg    <= GAIN_ROM[s3_k_reg];

        for (int c = 0; c < 3; c++)
        begin
            s1_d_reg[c]    <= d_full[c][21:0];
            s1_pos_reg[c]  <= pos_rd[32*c +: 32];
            s1_frc_reg[c]  <= frc_rd[32*c +: 32];
            s1_pv_reg[c]   <= $signed(vel_rd[32*c +: 32]) * jpfs_pkg::DAMP_Q16;
            s1_pf_reg[c]   <= $signed(frc_rd[32*c +: 32]) * jpfs_pkg::STEP_Q16;

            s2_d_reg[c]    <= s1_d_reg[c];
            s2_pos_reg[c]  <= s1_pos_reg[c];
            s2_frc_reg[c]  <= s1_frc_reg[c];
            s2_sq_reg[c]   <= 42'(s1_d_reg[c] * s1_d_reg[c]);
            s2_v_reg[c]    <= jpfs_pkg::sat32({s1_pv_reg[c][48], s1_pv_reg[c][48:16]}
                                              + {s1_pf_reg[c][48], s1_pf_reg[c][48:16]});

            s3_d_reg[c]    <= s2_d_reg[c];
            s3_pos_reg[c]  <= s2_pos_reg[c];
            s3_frc_reg[c]  <= s2_frc_reg[c];
            s3_v_reg[c]    <= s2_v_reg[c];
            s3_pp_reg[c]   <= s2_v_reg[c] * jpfs_pkg::STEP_Q16;

            s4_d_reg[c]    <= s3_d_reg[c];
            s4_frc_reg[c]  <= s3_frc_reg[c];
            s4_v_reg[c]    <= s3_v_reg[c];
            s4_p_reg[c]    <= jpfs_pkg::sat32({{2{s3_pos_reg[c][31]}}, s3_pos_reg[c]}
                                              + {s3_pp_reg[c][48], s3_pp_reg[c][48:16]});

            s5_frc_reg[c]  <= s4_frc_reg[c];
            s5_v_reg[c]    <= s4_v_reg[c];
            s5_p_reg[c]    <= s4_p_reg[c];
            s5_prod_reg[c] <= s4_g_reg * s4_d_reg[c];
        end
    end

    // ------------------------------------------------------------------
    // Memory write selection
    // ------------------------------------------------------------------
    logic clear_wr, fclear_wr, integ_wr, joint_wr, emit_wr;

    assign clear_wr  = (state_reg == jpfs_pkg::ST_CLEAR);
    assign fclear_wr = (state_reg == jpfs_pkg::ST_FCLEAR);
    assign integ_wr  = s5_vld_reg && !mode_joint_reg;
    assign joint_wr  = s5_vld_reg && mode_joint_reg && s5_hit_reg;
    assign emit_wr   = (state_reg == jpfs_pkg::ST_EMIT);

    always_comb
    begin
        pos_we    = clear_wr || integ_wr || emit_wr;
        vel_we    = clear_wr || integ_wr;
        frc_we    = clear_wr || fclear_wr || joint_wr;
        look_we   = clear_wr || emit_wr;

        pos_waddr  = clear_wr ? cnt_reg : (emit_wr ? emit_slot_reg : s5_idx_reg);
        vel_waddr  = clear_wr ? cnt_reg : s5_idx_reg;
        frc_waddr  = (clear_wr || fclear_wr) ? cnt_reg : s5_idx_reg;
        look_waddr = clear_wr ? cnt_reg : emit_slot_reg;

        if (clear_wr)
            pos_wdata = '0;
        else if (emit_wr)
            pos_wdata = {jnt_reg[2], jnt_reg[1], jnt_reg[0]};
        else
            pos_wdata = {s5_p_reg[2], s5_p_reg[1], s5_p_reg[0]};

        vel_wdata  = clear_wr ? '0 : {s5_v_reg[2], s5_v_reg[1], s5_v_reg[0]};
        frc_wdata  = (clear_wr || fclear_wr) ? '0 : {frc_new[2], frc_new[1], frc_new[0]};
        look_wdata = clear_wr ? jpfs_pkg::LOOK_RESET : frame_look_reg;

        raddr = (state_reg == jpfs_pkg::ST_SWEEP) ? cnt_reg : rd_addr_reg;
    end

    jpfs_ram #(.WIDTH(96), .DEPTH(PARTICLE_COUNT)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (raddr),
        .rdata (pos_rd)
    );

    jpfs_ram #(.WIDTH(96), .DEPTH(PARTICLE_COUNT)) u_vel_ram (
        .clk   (clk),
        .we    (vel_we),
        .waddr (vel_waddr),
        .wdata (vel_wdata),
        .raddr (raddr),
        .rdata (vel_rd)
    );

    jpfs_ram #(.WIDTH(96), .DEPTH(PARTICLE_COUNT)) u_frc_ram (
        .clk   (clk),
        .we    (frc_we),
        .waddr (frc_waddr),
        .wdata (frc_wdata),
        .raddr (raddr),
        .rdata (frc_rd)
    );

    jpfs_ram #(.WIDTH(jpfs_pkg::LOOK_W), .DEPTH(PARTICLE_COUNT)) u_look_ram (
        .clk   (clk),
        .we    (look_we),
        .waddr (look_waddr),
        .wdata (look_wdata),
        .raddr (raddr),
        .rdata (look_rd)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (rd_oor_reg)
                out_reg <= '0;
            else
                out_reg <= {2'b00, look_rd[13:0], look_rd[21:14],
                            look_rd[22] ? 8'h00 : 8'hFF,
                            look_rd[22] ? 8'h00 : 8'hFF,
                            8'hFF, pos_rd};
        end
    end

    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pipe_busy)
        else $error("sweep pipeline busy while taking a transaction");

    a_pos_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({clear_wr, integ_wr, emit_wr}))
        else $error("position store has two writers");

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        beat_reg != 2'd3)
        else $error("beat counter out of range");

    a_resp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jpfs_pkg::ST_READ) |=> (state_reg == jpfs_pkg::ST_RESP))
        else $error("read response skipped");

endmodule
